// File: hdl/egd_pkg.sv
// Shared constants, types and codes for the elevator group dispatcher.
package egd_pkg;

    localparam int NUM_CARS    = 8;
    localparam int NUM_FLOORS  = 64;
    localparam int QUEUE_SLOTS = 16;

    localparam int CAR_W   = 3;
    localparam int FLOOR_W = 6;
    localparam int LOAD_W  = 4;
    localparam int WAIT_W  = 5;
    localparam int QIDX_W  = 4;
    localparam int QLEN_W  = 5;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 10;
    localparam int BEST_W  = 12;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 2;

    localparam int DIST_SCALE = 10;
    localparam int BEST_SCALE = 30;

    localparam logic [CAR_W-1:0]   LAST_CAR   = CAR_W'(NUM_CARS - 1);
    localparam logic [FLOOR_W-1:0] TOP_FLOOR  = FLOOR_W'(NUM_FLOORS - 1);
    localparam logic [QLEN_W-1:0]  QUEUE_FULL = QLEN_W'(QUEUE_SLOTS);

    localparam logic [CIDX_W-1:0] REG_MOVE_TICKS    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_UNLOAD_TICKS  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_FLOORS_IN_USE = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_TASK = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ANSWER,
        S_CAR,
        S_QUEUE,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic car_step;
        logic q_step;
        logic next_car;
        logic clr_idx;
        logic emit_ans;
        logic emit_stat;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic scan_stop;
        logic car_idle;
        logic q_done;
        logic last_car;
    } t_stat;

endpackage

// File: hdl/egd_ctrl.sv
// Sequencer for the dispatcher: task scan, car walk, queue walk and report.
module egd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_req_type,
    input  egd_pkg::t_stat i_stat,
    output egd_pkg::t_cmd  o_cmd,
    output logic          busy
);

    egd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != egd_pkg::S_IDLE);
        unique case (r_state)
            egd_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == egd_pkg::REQ_TASK) begin
                        n_state = i_stat.full ? egd_pkg::S_ANSWER : egd_pkg::S_SCAN;
                    end else begin
                        n_state = egd_pkg::S_CAR;
                    end
                end
            end
            egd_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_stop) begin
                    n_state = egd_pkg::S_ANSWER;
                end
            end
            egd_pkg::S_ANSWER: begin
                o_cmd.emit_ans = 1'b1;
                n_state = egd_pkg::S_IDLE;
            end
            egd_pkg::S_CAR: begin
                o_cmd.car_step = 1'b1;
                if (i_stat.car_idle) begin
                    n_state = egd_pkg::S_QUEUE;
                end else if (i_stat.last_car) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state = egd_pkg::S_REPORT;
                end else begin
                    o_cmd.next_car = 1'b1;
                end
            end
            egd_pkg::S_QUEUE: begin
                if (!i_stat.q_done) begin
                    o_cmd.q_step = 1'b1;
                end else if (i_stat.last_car) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state = egd_pkg::S_REPORT;
                end else begin
                    o_cmd.next_car = 1'b1;
                    n_state = egd_pkg::S_CAR;
                end
            end
            egd_pkg::S_REPORT: begin
                o_cmd.emit_stat = 1'b1;
                if (i_stat.last_car) begin
                    n_state = egd_pkg::S_IDLE;
                end else begin
                    o_cmd.next_car = 1'b1;
                end
            end
            default: n_state = egd_pkg::S_IDLE;
        endcase
    end

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egd_pkg::S_SCAN && i_stat.scan_stop) |=> (r_state == egd_pkg::S_ANSWER))
        else $error("scan did not hand over to answer");

    a_report_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egd_pkg::S_REPORT && i_stat.last_car) |=> (r_state == egd_pkg::S_IDLE))
        else $error("report did not return to idle");

    a_queue_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egd_pkg::S_QUEUE) |-> ($past(r_state) == egd_pkg::S_CAR
                                          || $past(r_state) == egd_pkg::S_QUEUE))
        else $error("queue walk entered from wrong state");

endmodule

// File: hdl/egd_dp.sv
// Datapath for the dispatcher: car state, task queue, time counter, result word.
module egd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  egd_pkg::t_cmd                 i_cmd,
    output egd_pkg::t_stat                o_stat,
    input  logic                          i_req_type,
    input  logic [egd_pkg::FLOOR_W-1:0]   i_from_floor,
    input  logic [egd_pkg::FLOOR_W-1:0]   i_to_floor,
    input  logic [egd_pkg::LOAD_W-1:0]    i_riders,
    input  logic                          i_cfg_we,
    input  logic [egd_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [egd_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic                          o_kind,
    output logic [egd_pkg::CAR_W-1:0]     o_car,
    output logic [egd_pkg::FLOOR_W-1:0]   o_car_floor,
    output logic [egd_pkg::FLOOR_W-1:0]   o_car_target,
    output logic [egd_pkg::LOAD_W-1:0]    o_car_load,
    output logic                          o_accepted,
    output logic [egd_pkg::TIME_W-1:0]    o_time_count,
    output logic                          o_last
);

    logic [egd_pkg::WAIT_W-1:0]  r_move, r_unload;
    logic [egd_pkg::CFG_W-1:0]   r_floors;

    logic [egd_pkg::FLOOR_W-1:0] r_floor  [egd_pkg::NUM_CARS];
    logic [egd_pkg::FLOOR_W-1:0] r_target [egd_pkg::NUM_CARS];
    logic [egd_pkg::LOAD_W-1:0]  r_load   [egd_pkg::NUM_CARS];
    logic [egd_pkg::WAIT_W-1:0]  r_wait   [egd_pkg::NUM_CARS];

    logic [egd_pkg::FLOOR_W-1:0] r_q_pick [egd_pkg::QUEUE_SLOTS];
    logic                        r_q_done [egd_pkg::QUEUE_SLOTS];
    logic [egd_pkg::FLOOR_W-1:0] r_q_dest [egd_pkg::QUEUE_SLOTS];
    logic [egd_pkg::LOAD_W-1:0]  r_q_ride [egd_pkg::QUEUE_SLOTS];
    logic [egd_pkg::CAR_W-1:0]   r_q_car  [egd_pkg::QUEUE_SLOTS];
    logic [egd_pkg::QLEN_W-1:0]  r_qlen;

    logic [egd_pkg::TIME_W-1:0]  r_time;
    logic [egd_pkg::CAR_W-1:0]   r_i, r_pick;
    logic [egd_pkg::QLEN_W-1:0]  r_j;
    logic [egd_pkg::BEST_W-1:0]  r_best;
    logic                        r_ok;
    logic [egd_pkg::FLOOR_W-1:0] r_from, r_dest;
    logic [egd_pkg::LOAD_W-1:0]  r_riders;

    logic                        r_o_strobe;
    logic                        r_o_kind, r_o_acc, r_o_last;
    logic [egd_pkg::CAR_W-1:0]   r_o_car;
    logic [egd_pkg::FLOOR_W-1:0] r_o_floor, r_o_target;
    logic [egd_pkg::LOAD_W-1:0]  r_o_load;
    logic [egd_pkg::TIME_W-1:0]  r_o_time;

    logic [egd_pkg::FLOOR_W-1:0] cf, ct, diff, from_c, dest_c, goal;
    logic [egd_pkg::LOAD_W-1:0]  cl, people;
    logic [egd_pkg::WAIT_W-1:0]  cw;
    logic [egd_pkg::DIST_W-1:0]  span;
    logic                        better, car_idle;
    logic [egd_pkg::CAR_W-1:0]   n_pick;
    logic [egd_pkg::QIDX_W-1:0]  qj, qw;

    assign cf = r_floor[r_i];
    assign ct = r_target[r_i];
    assign cl = r_load[r_i];
    assign cw = r_wait[r_i];
    assign qj = r_j[egd_pkg::QIDX_W-1:0];
    assign qw = r_qlen[egd_pkg::QIDX_W-1:0];

    assign from_c = (i_from_floor > egd_pkg::TOP_FLOOR) ? egd_pkg::TOP_FLOOR : i_from_floor;
    assign dest_c = (i_to_floor > egd_pkg::TOP_FLOOR) ? egd_pkg::TOP_FLOOR : i_to_floor;

    assign diff     = (cf > r_from) ? (cf - r_from) : (r_from - cf);
    assign span     = egd_pkg::DIST_W'(diff) * egd_pkg::DIST_W'(egd_pkg::DIST_SCALE);
    assign better   = (egd_pkg::BEST_W'(span) < r_best);
    assign n_pick   = better ? r_i : r_pick;
    assign car_idle = (cf == ct) && (cl == '0);

    assign goal   = r_q_done[qj] ? r_q_dest[qj] : r_q_pick[qj];
    assign people = r_q_done[qj] ? r_q_ride[qj] : '0;

    assign o_stat.full      = (r_qlen >= egd_pkg::QUEUE_FULL);
    assign o_stat.scan_stop = (better && span == '0) || (r_i == egd_pkg::LAST_CAR);
    assign o_stat.car_idle  = car_idle;
    assign o_stat.q_done    = (r_j >= r_qlen);
    assign o_stat.last_car  = (r_i == egd_pkg::LAST_CAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move   <= egd_pkg::WAIT_W'(10);
            r_unload <= egd_pkg::WAIT_W'(20);
            r_floors <= egd_pkg::CFG_W'(50);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                egd_pkg::REG_MOVE_TICKS:    r_move   <= i_cfg_data[egd_pkg::WAIT_W-1:0];
                egd_pkg::REG_UNLOAD_TICKS:  r_unload <= i_cfg_data[egd_pkg::WAIT_W-1:0];
                egd_pkg::REG_FLOORS_IN_USE: r_floors <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < egd_pkg::NUM_CARS; k++) begin
                r_floor[k]  <= '0;
                r_target[k] <= '0;
                r_load[k]   <= '0;
                r_wait[k]   <= '0;
            end
            r_qlen <= '0;
            r_time <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_i      <= '0;
                r_pick   <= '0;
                r_from   <= from_c;
                r_dest   <= dest_c;
                r_riders <= i_riders;
                r_best   <= egd_pkg::BEST_W'(r_floors) * egd_pkg::BEST_W'(egd_pkg::BEST_SCALE);
                r_ok     <= !o_stat.full;
                if (i_req_type == egd_pkg::REQ_TICK) begin
                    r_time <= r_time + 1'b1;
                end
            end
            if (i_cmd.scan) begin
                r_time <= r_time + 1'b1;
                r_pick <= n_pick;
                if (better) begin
                    r_best <= egd_pkg::BEST_W'(span);
                end
                if (o_stat.scan_stop) begin
                    r_q_pick[qw] <= r_from;
                    r_q_done[qw] <= 1'b0;
                    r_q_dest[qw] <= r_dest;
                    r_q_ride[qw] <= r_riders;
                    r_q_car[qw]  <= n_pick;
                    r_qlen       <= r_qlen + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (i_cmd.car_step) begin
                r_j <= '0;
                if (cf != ct) begin
                    if (cw >= r_move) begin
                        r_floor[r_i] <= (cf < ct) ? cf + 1'b1 : cf - 1'b1;
                        r_wait[r_i]  <= egd_pkg::WAIT_W'(1);
                    end else begin
                        r_wait[r_i]  <= cw + 1'b1;
                    end
                end else if (cl != '0) begin
                    if (cw >= r_unload) begin
                        r_load[r_i] <= '0;
                        r_wait[r_i] <= '0;
                    end else begin
                        r_wait[r_i] <= cw + 1'b1;
                    end
                end
            end
            if (i_cmd.q_step) begin
                if (r_q_car[qj] != r_i) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    if (cf != goal) begin
                        r_target[r_i] <= goal;
                    end
                    r_load[r_i] <= people;
                    if (!r_q_done[qj]) begin
                        r_q_done[qj] <= 1'b1;
                        r_j <= r_j + 1'b1;
                    end else begin
                        for (int k = 0; k < egd_pkg::QUEUE_SLOTS - 1; k++) begin
                            if (k >= int'(qj)) begin
                                r_q_pick[k] <= r_q_pick[k+1];
                                r_q_done[k] <= r_q_done[k+1];
                                r_q_dest[k] <= r_q_dest[k+1];
                                r_q_ride[k] <= r_q_ride[k+1];
                                r_q_car[k]  <= r_q_car[k+1];
                            end
                        end
                        r_qlen <= r_qlen - 1'b1;
                    end
                end
            end
            if (i_cmd.next_car) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.clr_idx) begin
                r_i <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= i_cmd.emit_ans || i_cmd.emit_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ans) begin
            r_o_kind   <= egd_pkg::KIND_ANSWER;
            r_o_car    <= r_ok ? r_pick : '0;
            r_o_floor  <= r_ok ? r_floor[r_pick] : '0;
            r_o_target <= r_ok ? r_target[r_pick] : '0;
            r_o_load   <= r_ok ? r_load[r_pick] : '0;
            r_o_acc    <= r_ok;
            r_o_time   <= r_time;
            r_o_last   <= 1'b1;
        end else if (i_cmd.emit_stat) begin
            r_o_kind   <= egd_pkg::KIND_STATUS;
            r_o_car    <= r_i;
            r_o_floor  <= cf;
            r_o_target <= ct;
            r_o_load   <= cl;
            r_o_acc    <= 1'b0;
            r_o_time   <= r_time;
            r_o_last   <= (r_i == egd_pkg::LAST_CAR);
        end
    end

    assign o_strobe     = r_o_strobe;
    assign o_kind       = r_o_kind;
    assign o_car        = r_o_car;
    assign o_car_floor  = r_o_floor;
    assign o_car_target = r_o_target;
    assign o_car_load   = r_o_load;
    assign o_accepted   = r_o_acc;
    assign o_time_count = r_o_time;
    assign o_last       = r_o_last;

    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= egd_pkg::QUEUE_FULL)
        else $error("queue length beyond capacity");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last && o_kind == egd_pkg::KIND_STATUS) |-> (o_car == egd_pkg::LAST_CAR))
        else $error("status word marked last on wrong car");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == egd_pkg::KIND_ANSWER && !o_accepted)
            |-> (o_car == '0 && o_car_load == '0))
        else $error("rejected task word carries car data");

endmodule

// File: hdl/elevator_group_dispatcher.sv
// Top level of the elevator group dispatcher.
//  channel   direction  handshake          payload
//  request   in         start & !busy      i_req_type i_from_floor i_to_floor i_riders
//  result    out        o_strobe, 1 cycle  o_kind o_car o_car_floor o_car_target
//                                          o_car_load o_accepted o_time_count o_last
//  config    in         i_cfg_we           i_cfg_idx i_cfg_data
// After the accepting edge busy stays high for a task while the cars are scanned in order
// until one stands at the pick-up floor or the last car is done, then for the answer; a task
// on a full queue skips the scan. A tick steps each car in turn, walks the queue for each
// idle car, then reports a status word per car.
// Each word reaches the outputs in the cycle after it is formed; reset is synchronous.
// Results cannot be stalled; busy falls as the last word is issued.
module elevator_group_dispatcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [egd_pkg::FLOOR_W-1:0]   i_from_floor,
    input  logic [egd_pkg::FLOOR_W-1:0]   i_to_floor,
    input  logic [egd_pkg::LOAD_W-1:0]    i_riders,
    input  logic                          i_cfg_we,
    input  logic [egd_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [egd_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic                          o_kind,
    output logic [egd_pkg::CAR_W-1:0]     o_car,
    output logic [egd_pkg::FLOOR_W-1:0]   o_car_floor,
    output logic [egd_pkg::FLOOR_W-1:0]   o_car_target,
    output logic [egd_pkg::LOAD_W-1:0]    o_car_load,
    output logic                          o_accepted,
    output logic [egd_pkg::TIME_W-1:0]    o_time_count,
    output logic                          o_last
);

    egd_pkg::t_cmd  cmd;
    egd_pkg::t_stat stat;

    egd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    egd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_from_floor (i_from_floor),
        .i_to_floor   (i_to_floor),
        .i_riders     (i_riders),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_car        (o_car),
        .o_car_floor  (o_car_floor),
        .o_car_target (o_car_target),
        .o_car_load   (o_car_load),
        .o_accepted   (o_accepted),
        .o_time_count (o_time_count),
        .o_last       (o_last)
    );

endmodule
